// ----- src/sorted_set_table_defines.svh -----
// ----------------------------------------------------------------------------
// sorted_set_table_defines: assertion macros for the sorted set table
// Shared concurrent assertion forms, clocked and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef SORTED_SET_TABLE_DEFINES_SVH
`define SORTED_SET_TABLE_DEFINES_SVH

// same-cycle implication
`define SST_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sorted_set_table: assertion failed");

// next-cycle implication
`define SST_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sorted_set_table: assertion failed");

`endif

// ----- src/sst_pkg.sv -----
// ----------------------------------------------------------------------------
// sst_pkg: types and constants of the sorted set table
// Request/response structs, operation codes, FSM states, cell control.
// ----------------------------------------------------------------------------
package sst_pkg;

  localparam int CAPACITY = 64;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  localparam logic [1:0] KIND_ADD    = 2'd0;
  localparam logic [1:0] KIND_CHECK  = 2'd1;
  localparam logic [1:0] KIND_DELETE = 2'd2;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [31:0] value;
  } req_t;

  typedef struct packed {
    logic       found;
    logic       status;
    logic [6:0] count;
  } rsp_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMP,
    ST_RES,
    ST_APPLY
  } state_t;

  typedef struct packed {
    logic cmp;
    logic ins;
    logic del;
  } cell_ctrl_t;

endpackage

// ----- src/sorted_set_table.sv -----
// ----------------------------------------------------------------------------
// sorted_set_table: bounded sorted set of signed 32-bit values
// Add / check / delete one value per request over a chain of compare cells.
//
//   channel | signals                  | payload
//   --------+--------------------------+------------------------------
//   request | req_valid, req_ready     | req  (kind, value)
//   result  | rsp_valid, rsp_ready     | rsp  (found, status, count)
//
// After acceptance a request steps through ST_CMP (compare in every cell),
// ST_RES (OR of the match flags) and ST_APPLY (the shift across the chain);
// a new request is accepted only back in ST_IDLE, after the shift.
// Reset clears the count and control only; cell contents need no clearing.
// The shift waits while the result register is full and not taken.
// ----------------------------------------------------------------------------
`include "sorted_set_table_defines.svh"

module sorted_set_table import sst_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);

  state_t     state, state_next;
  req_t       cur;
  logic [CNT_W-1:0] cnt;
  logic       found;
  cell_ctrl_t ctrl;
  logic       apply_go;
  logic       is_add, is_del, full, ins_en, del_en;

  logic signed [31:0] vals [CAPACITY];
  logic [CAPACITY-1:0] less_vec;
  logic [CAPACITY-1:0] eq_vec;

  assign is_add = (cur.kind == KIND_ADD);
  assign is_del = (cur.kind == KIND_DELETE);
  assign full   = (cnt == CNT_W'(CAPACITY));
  assign ins_en = is_add && !found && !full;
  assign del_en = is_del && found;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (req_valid) state_next = ST_CMP;
      ST_CMP:   state_next = ST_RES;
      ST_RES:   state_next = ST_APPLY;
      ST_APPLY: if (!rsp_valid || rsp_ready) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    req_ready = 1'b0;
    apply_go  = 1'b0;
    ctrl      = '0;
    unique case (state)
      ST_IDLE:  req_ready = 1'b1;
      ST_CMP:   ctrl.cmp = 1'b1;
      ST_RES:   ;
      ST_APPLY: begin
        apply_go = !rsp_valid || rsp_ready;
        ctrl.ins = apply_go && ins_en;
        ctrl.del = apply_go && del_en;
      end
      default:  ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt       <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (apply_go) begin
        rsp_valid <= 1'b1;
        if (ins_en) begin
          cnt <= cnt + CNT_W'(1);
        end else if (del_en) begin
          cnt <= cnt - CNT_W'(1);
        end
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      cur <= req;
    end
    if (state == ST_RES) begin
      found <= |eq_vec;
    end
    if (apply_go) begin
      rsp.found  <= found;
      rsp.status <= is_add && !found && full;
      if (ins_en) begin
        rsp.count <= 7'(cnt + CNT_W'(1));
      end else if (del_en) begin
        rsp.count <= 7'(cnt - CNT_W'(1));
      end else begin
        rsp.count <= 7'(cnt);
      end
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [31:0] lv, rv;
    logic               ll;
    if (i == 0) begin : g_first
      assign lv = cur.value;
      assign ll = 1'b1;
    end else begin : g_mid
      assign lv = vals[i-1];
      assign ll = less_vec[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign rv = vals[i];
    end else begin : g_inner
      assign rv = vals[i+1];
    end

    sst_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .key       (cur.value),
      .occ       (CNT_W'(i) < cnt),
      .left_val  (lv),
      .left_less (ll),
      .right_val (rv),
      .val       (vals[i]),
      .less      (less_vec[i]),
      .eq        (eq_vec[i])
    );
  end

  `SST_ASSERT_IMPL(a_cnt_bound, clk, rst, 1'b1, cnt <= CNT_W'(CAPACITY))
  `SST_ASSERT_IMPL(a_rsp_count, clk, rst, rsp_valid, rsp.count == 7'(cnt))
  `SST_ASSERT_IMPL(a_reject_absent, clk, rst, rsp_valid && rsp.status, !rsp.found)
  `SST_ASSERT_NEXT(a_ins_grow, clk, rst, ctrl.ins, cnt == $past(cnt) + CNT_W'(1))
  `SST_ASSERT_NEXT(a_del_shrink, clk, rst, ctrl.del, cnt == $past(cnt) - CNT_W'(1))

endmodule

// ----- src/sst_cell.sv -----
// ----------------------------------------------------------------------------
// sst_cell: one slot of the sorted set chain
// Holds one element, compares it against the request value, and on update
// takes the request value or a neighbor's element.
// ----------------------------------------------------------------------------
module sst_cell import sst_pkg::*; (
  input  logic               clk,
  input  cell_ctrl_t         ctrl,
  input  logic signed [31:0] key,
  input  logic               occ,
  input  logic signed [31:0] left_val,
  input  logic               left_less,
  input  logic signed [31:0] right_val,
  output logic signed [31:0] val,
  output logic               less,
  output logic               eq
);

  always_ff @(posedge clk) begin
    if (ctrl.cmp) begin
      less <= occ && (val < key);
      eq   <= occ && (val == key);
    end
    if (ctrl.ins) begin
      if (!less) begin
        val <= left_less ? key : left_val;
      end
    end else if (ctrl.del) begin
      if (!less) begin
        val <= right_val;
      end
    end
  end

endmodule

// ----- test/sorted_set_table_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sorted_set_table_tb: self-checking bench for the sorted set table
// Drives add/check/delete/spare requests with bursty valid, stalling ready.
// A scoreboard keeps its own sorted copy of the set, predicts found, status
// and count for every accepted request, and checks the results in order.
// Directed corner requests come first, then alternating fill/drain phases.
// ----------------------------------------------------------------------------
module sorted_set_table_tb;
  import sst_pkg::*;

  localparam logic [1:0]         KIND_SPARE  = 2'd3;
  localparam logic signed [31:0] VAL_MIN     = 32'sh8000_0000;
  localparam logic signed [31:0] VAL_MAX     = 32'sh7fff_ffff;
  localparam int                 RANDOM_REQS = 400;
  localparam int                 PHASE_LEN   = 100;

  class set_scoreboard;
    logic signed [31:0] members[$];
    rsp_t               expected[$];
    int                 errors = 0;

    function void note_request(req_t r);
      logic signed [31:0] v;
      int                 pos;
      bit                 hit;
      rsp_t               p;
      v   = r.value;
      pos = 0;
      while (pos < members.size() && members[pos] < v) pos++;
      hit      = (pos < members.size()) && (members[pos] == v);
      p.found  = hit;
      p.status = 1'b0;
      if (r.kind == KIND_ADD && !hit) begin
        if (members.size() >= CAPACITY) p.status = 1'b1;
        else members.insert(pos, v);
      end else if (r.kind == KIND_DELETE && hit) begin
        members.delete(pos);
      end
      p.count = 7'(members.size());
      expected.push_back(p);
    endfunction

    function void check_result(rsp_t got);
      rsp_t want;
      if (expected.size() == 0) begin
        $display("%0t: result with none expected: found=%0b status=%0b count=%0d",
                 $time, got.found, got.status, got.count);
        errors++;
        return;
      end
      want = expected.pop_front();
      if (got.found !== want.found) begin
        $display("%0t: found expected %0b actual %0b", $time, want.found, got.found);
        errors++;
      end
      if (got.status !== want.status) begin
        $display("%0t: status expected %0b actual %0b", $time, want.status, got.status);
        errors++;
      end
      if (got.count !== want.count) begin
        $display("%0t: count expected %0d actual %0d", $time, want.count, got.count);
        errors++;
      end
    endfunction
  endclass

  logic          clk       = 1'b0;
  logic          rst       = 1'b1;
  logic          req_valid = 1'b0;
  logic          req_ready;
  req_t          req       = '0;
  logic          rsp_valid;
  logic          rsp_ready = 1'b0;
  rsp_t          rsp;

  set_scoreboard sb        = new;
  int            burst_left = 0;
  logic [15:0]   stall_pat  = 16'hffff;
  int            pat_age    = 0;

  sorted_set_table DUT (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  always #5 clk = ~clk;

  // result-side stall pattern, reshuffled whenever pat_age wraps
  always @(posedge clk) begin
    if (rst) begin
      rsp_ready <= 1'b0;
      pat_age   <= 0;
    end else begin
      if (pat_age == 63) begin
        case ($urandom_range(0, 3))
          0:       stall_pat <= 16'hffff;
          1:       stall_pat <= 16'($urandom);
          default: stall_pat <= 16'($urandom | $urandom);
        endcase
        pat_age <= 0;
      end else begin
        stall_pat <= {stall_pat[0], stall_pat[15:1]};
        pat_age   <= pat_age + 1;
      end
      rsp_ready <= stall_pat[0];
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp_valid && rsp_ready) sb.check_result(rsp);
  end

  task automatic send(input logic [1:0] kind, input logic signed [31:0] value);
    if (burst_left == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 12);
    end
    burst_left--;
    req_valid  <= 1'b1;
    req.kind   <= kind;
    req.value  <= value;
    do @(posedge clk); while (!req_ready);
    sb.note_request(req);
  endtask

  task automatic drain();
    req_valid <= 1'b0;
    do @(posedge clk); while (sb.expected.size() != 0);
  endtask

  // fill phases favor fresh adds to reach a full set; drain phases remove members
  function automatic req_t pick_request(bit filling);
    int                 r;
    int                 n;
    int                 tiny;
    logic signed [31:0] member;
    req_t               q;
    r      = $urandom_range(0, 99);
    n      = sb.members.size();
    tiny   = $urandom_range(0, 15) - 8;
    member = (n > 0) ? sb.members[$urandom_range(0, n - 1)] : $signed($urandom);
    q.value = $signed($urandom);
    if (filling) begin
      if (r < 70) q.kind = KIND_ADD;
      else if (r < 78) begin
        q.kind  = KIND_ADD;
        q.value = member;
      end else if (r < 84) begin
        q.kind  = KIND_ADD;
        q.value = tiny;
      end else if (r < 90) begin
        q.kind  = KIND_CHECK;
        q.value = member;
      end else if (r < 93) q.kind = KIND_CHECK;
      else if (r < 96) begin
        q.kind  = KIND_DELETE;
        q.value = member;
      end else q.kind = KIND_SPARE;
    end else begin
      if (r < 60) begin
        q.kind  = KIND_DELETE;
        q.value = member;
      end else if (r < 68) begin
        q.kind  = KIND_DELETE;
        q.value = tiny;
      end else if (r < 78) begin
        q.kind  = KIND_CHECK;
        q.value = member;
      end else if (r < 88) q.kind = KIND_ADD;
      else if (r < 94) q.kind = KIND_CHECK;
      else begin
        q.kind  = KIND_SPARE;
        q.value = member;
      end
    end
    return q;
  endfunction

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    send(KIND_CHECK, 0);
    send(KIND_DELETE, 5);
    send(KIND_ADD, 0);
    send(KIND_ADD, VAL_MIN);
    send(KIND_ADD, VAL_MAX);
    send(KIND_ADD, -1);
    send(KIND_ADD, 1);
    send(KIND_ADD, 0);
    send(KIND_ADD, VAL_MAX);
    send(KIND_CHECK, VAL_MIN);
    send(KIND_CHECK, VAL_MAX);
    send(KIND_CHECK, 2);
    send(KIND_SPARE, -1);
    send(KIND_SPARE, 7);
    send(KIND_DELETE, VAL_MAX);
    send(KIND_DELETE, VAL_MIN);
    send(KIND_DELETE, 0);
    send(KIND_DELETE, 0);
    send(KIND_CHECK, 0);
    send(KIND_DELETE, 1);
    send(KIND_DELETE, -1);
    send(KIND_CHECK, -1);
    drain();

    for (int i = 0; i < RANDOM_REQS; i++) begin
      req_t q;
      q = pick_request(((i / PHASE_LEN) % 2) == 0);
      send(q.kind, q.value);
      if (i % PHASE_LEN == PHASE_LEN - 1) drain();
    end

    repeat (20) @(posedge clk);
    if (sb.errors == 0) begin
      $display("sorted_set_table_tb: done, clean");
    end else begin
      $display("sorted_set_table_tb: done, errors");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("sorted_set_table_tb: done, errors");
    $finish;
  end

endmodule
